@@ design/npcb_pkg.sv @@
// Shared constants, types and helper functions for the custom base number parser.
package npcb_pkg;

  // Alphabet storage always holds sixteen symbol slots; MAX_SYMBOLS caps how many are used.
  localparam int SLOT_COUNT     = 16;
  localparam int MAX_SYMBOLS    = 16;
  localparam int CHAR_W         = 8;
  localparam int VALUE_W        = 32;
  localparam int RADIX_W        = 5;
  localparam int POS_W          = $clog2(SLOT_COUNT);
  localparam int CFG_DATA_W     = 64;
  localparam int CFG_IDX_W      = 2;
  localparam int SLOTS_PER_WORD = CFG_DATA_W / CHAR_W;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_ALPHA_LOW  = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_ALPHA_HIGH = cfg_idx_t'(1);
  localparam cfg_idx_t CFG_RADIX      = cfg_idx_t'(2);

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'd43;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;

  localparam logic [RADIX_W-1:0] MAX_SYM_R = RADIX_W'(MAX_SYMBOLS);
  localparam logic [RADIX_W-1:0] MIN_RADIX = RADIX_W'(2);

  typedef enum logic [1:0] {
    PH_SPACE,
    PH_SIGN,
    PH_DIGIT,
    PH_STOP
  } phase_t;

  typedef logic [SLOT_COUNT-1:0][CHAR_W-1:0] alphabet_t;

  typedef struct packed {
    logic                    ok;
    logic [RADIX_W-1:0]      radix;
    logic [SLOT_COUNT-1:0]   used;
  } alpha_status_t;

  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] pos;
  } digit_t;

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_sign(input logic [CHAR_W-1:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

endpackage

@@ design/npcb_in_if.sv @@
// Input byte stream channel.
interface npcb_in_if;
  import npcb_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

@@ design/npcb_out_if.sv @@
// Result channel carrying the parsed value and the alphabet check flag.
interface npcb_out_if;
  import npcb_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      alphabet_ok;

  modport source (output valid, output value, output alphabet_ok, input ready);
  modport sink   (input valid, input value, input alphabet_ok, output ready);
endinterface

@@ design/npcb_cfg_if.sv @@
// Configuration write channel.
interface npcb_cfg_if;
  import npcb_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/npcb_cfg.sv @@
// Configuration registers and the alphabet validity check.
module npcb_cfg (
  input  logic                    clk,
  input  logic                    rst_n,
  npcb_cfg_if.sink                cfg_ch,
  output npcb_pkg::alphabet_t     alphabet,
  output npcb_pkg::alpha_status_t status
);
  import npcb_pkg::*;

  logic [CFG_DATA_W-1:0] alpha_low_r,  alpha_low_nxt;
  logic [CFG_DATA_W-1:0] alpha_high_r, alpha_high_nxt;
  logic [RADIX_W-1:0]    radix_r,      radix_nxt;
  logic                  alpha_ok;
  logic [RADIX_W-1:0]    used_n;
  logic [SLOT_COUNT-1:0] used;
  logic                  wr;

  assign cfg_ch.ready = 1'b1;
  assign wr = cfg_ch.valid && cfg_ch.ready;

  always_comb begin
    alpha_low_nxt  = alpha_low_r;
    alpha_high_nxt = alpha_high_r;
    radix_nxt      = radix_r;
    if (wr) begin
      case (cfg_ch.index)
        CFG_ALPHA_LOW:  alpha_low_nxt  = cfg_ch.data;
        CFG_ALPHA_HIGH: alpha_high_nxt = cfg_ch.data;
        CFG_RADIX:      radix_nxt      = cfg_ch.data[RADIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_low_r  <= '0;
      alpha_high_r <= '0;
      radix_r      <= '0;
    end else begin
      alpha_low_r  <= alpha_low_nxt;
      alpha_high_r <= alpha_high_nxt;
      radix_r      <= radix_nxt;
    end
  end

  // Low word fills slots 0 to 7, high word slots 8 to 15.
  always_comb begin
    for (int i = 0; i < SLOTS_PER_WORD; i++) begin
      alphabet[i]                  = alpha_low_r[i*CHAR_W +: CHAR_W];
      alphabet[i + SLOTS_PER_WORD] = alpha_high_r[i*CHAR_W +: CHAR_W];
    end
  end

  assign used_n = (radix_r > MAX_SYM_R) ? MAX_SYM_R : radix_r;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      used[i] = RADIX_W'(i) < used_n;
    end
  end

  // A valid alphabet has a legal length, no banned symbol and no repeated symbol.
  always_comb begin
    alpha_ok = (radix_r >= MIN_RADIX) && (radix_r <= MAX_SYM_R);
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (used[i] && (alphabet[i] == CH_NUL || is_sign(alphabet[i]) ||
                      alphabet[i] == CH_SPACE)) begin
        alpha_ok = 1'b0;
      end
      for (int j = i + 1; j < SLOT_COUNT; j++) begin
        if (used[j] && (alphabet[i] == alphabet[j])) begin
          alpha_ok = 1'b0;
        end
      end
    end
  end

  assign status.ok    = alpha_ok;
  assign status.radix = radix_r;
  assign status.used  = used;

endmodule

@@ design/npcb_match.sv @@
// Parallel compare of one byte against the alphabet, lowest matching slot wins.
module npcb_match (
  input  logic [npcb_pkg::CHAR_W-1:0]  char_code,
  input  npcb_pkg::alphabet_t          alphabet,
  input  npcb_pkg::alpha_status_t      status,
  output npcb_pkg::digit_t             digit
);
  import npcb_pkg::*;

  logic [SLOT_COUNT-1:0] hit_vec;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      hit_vec[i] = status.used[i] && (alphabet[i] == char_code);
    end
  end

  always_comb begin
    digit.hit = |hit_vec;
    digit.pos = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        digit.pos = POS_W'(i);
      end
    end
  end

endmodule

@@ design/npcb_core.sv @@
// Input stage, parse state update and result register.
module npcb_core (
  input  logic                        clk,
  input  logic                        rst_n,
  npcb_in_if.sink                     in_ch,
  npcb_out_if.source                  out_ch,
  input  npcb_pkg::alpha_status_t     status,
  input  npcb_pkg::digit_t            digit,
  output logic [npcb_pkg::CHAR_W-1:0] cur_char
);
  import npcb_pkg::*;

  logic                      s1_valid_r, s1_valid_nxt;
  logic [CHAR_W-1:0]         s1_char_r,  s1_char_nxt;
  phase_t                    phase_r,    phase_nxt;
  logic                      neg_r,      neg_nxt;
  logic [VALUE_W-1:0]        acc_r,      acc_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]        out_value_r, out_value_nxt;
  logic                      out_ok_r,    out_ok_nxt;
  logic                      out_free;
  logic                      s1_go;
  logic                      in_take;
  logic                      emit;
  logic                      is_end;
  logic [VALUE_W-1:0]        signed_acc;

  assign is_end   = (s1_char_r == CH_NUL);
  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_go    = s1_valid_r && (!is_end || out_free);
  assign emit     = s1_go && is_end;
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign in_take  = in_ch.valid && in_ch.ready;
  assign cur_char = s1_char_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_char_nxt  = s1_char_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
      s1_char_nxt  = in_ch.char_code;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  assign signed_acc = neg_r ? (VALUE_W'(0) - acc_r) : acc_r;

  // Parse state machine, advanced once per byte leaving the input stage.
  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    if (s1_go) begin
      if (is_end) begin
        phase_nxt = PH_SPACE;
        neg_nxt   = 1'b0;
        acc_nxt   = '0;
      end else if (phase_r == PH_STOP) begin
        phase_nxt = PH_STOP;
      end else if (phase_r == PH_SPACE && is_space(s1_char_r)) begin
        phase_nxt = PH_SPACE;
      end else if ((phase_r == PH_SPACE || phase_r == PH_SIGN) && is_sign(s1_char_r)) begin
        phase_nxt = PH_SIGN;
        neg_nxt   = neg_r ^ (s1_char_r == CH_MINUS);
      end else if (digit.hit) begin
        phase_nxt = PH_DIGIT;
        acc_nxt   = VALUE_W'(acc_r * VALUE_W'(status.radix)) + VALUE_W'(digit.pos);
      end else begin
        phase_nxt = PH_STOP;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_ok_nxt    = out_ok_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = status.ok ? signed_acc : '0;
      out_ok_nxt    = status.ok;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      phase_r     <= PH_SPACE;
      neg_r       <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      phase_r     <= phase_nxt;
      neg_r       <= neg_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_char_r   <= s1_char_nxt;
    out_value_r <= out_value_nxt;
    out_ok_r    <= out_ok_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.value       = signed'(out_value_r);
  assign out_ch.alphabet_ok = out_ok_r;

endmodule

@@ design/number_parse_custom_base.sv @@
// Top level of the signed integer parser with a configurable digit alphabet.
// A zero byte is registered in the input stage, then its result in the output register.
// One byte per cycle unless a zero byte waits on a held result; one state step per byte.
// The limiting path is the alphabet compare followed by the 32 by 5 bit multiply-add.
// Reset (synchronous, rst_n low) clears the parse state, both pipeline stages and
// the configuration registers; no result is pending after reset.
module number_parse_custom_base (
  input  logic       clk,
  input  logic       rst_n,
  npcb_in_if.sink    in_ch,
  npcb_out_if.source out_ch,
  npcb_cfg_if.sink   cfg_ch
);
  import npcb_pkg::*;

  // Alphabet symbols, radix and the validity flag. The flag is worked out
  // directly from the configuration registers, so a zero byte is always judged
  // against the alphabet as it stands in the cycle that the byte is processed.
  alphabet_t         alphabet;
  alpha_status_t     status;

  // The byte held in the input stage and its match against the alphabet.
  logic [CHAR_W-1:0] cur_char;
  digit_t            digit;

  npcb_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_ch   (cfg_ch),
    .alphabet (alphabet),
    .status   (status)
  );

  // All sixteen slots are compared at once; only slots below the radix count.
  npcb_match u_match (
    .char_code (cur_char),
    .alphabet  (alphabet),
    .status    (status),
    .digit     (digit)
  );

  // The core registers each input transfer, advances the whitespace, sign and
  // digit phases, and places a result in the output register at each zero
  // byte. A new byte is taken while a finished result still waits in the
  // output register; only a zero byte waits for the output register to free.
  npcb_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .status   (status),
    .digit    (digit),
    .cur_char (cur_char)
  );

endmodule
